@@ rtl/plpd_pkg.sv @@
// Shared types, codes and helpers for the pinned LRU page directory.
package plpd_pkg;

   // Sizing limits and fixed field widths
   localparam int CAP_DEFAULT = 16;
   localparam int CAP_MAX     = 64;
   localparam int SLOT_IW     = 6;    // slot index / recency rank width at CAP_MAX
   localparam int FL_W        = 7;    // counts up to CAP_MAX
   localparam int PAGE_W      = 32;
   localparam int PIN_W       = 16;
   localparam int LIMIT_W     = 5;
   localparam int CNT_W       = 32;

   // Configuration register indexes (byte address bit 2)
   localparam logic REG_LIMIT = 1'b0;
   localparam logic REG_STORE = 1'b1;

   typedef enum logic [2:0] {
      F_GET       = 3'd0,
      F_UNPIN     = 3'd1,
      F_DIRTY     = 3'd2,
      F_FLUSH     = 3'd3,
      F_FLUSH_ALL = 3'd4,
      F_EVICT     = 3'd5,
      F_CLEAR     = 3'd6,
      F_RSTAT     = 3'd7
   } func_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_LOADED    = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_PINNED    = 3'd3,
      ST_NO_VICTIM = 3'd4,
      ST_NO_STORE  = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      ACT_NONE = 2'd0,
      ACT_READ = 2'd1,
      ACT_WB   = 2'd2
   } action_type;

   // Broadcast command applied by every slot cell in the same cycle
   typedef enum logic [2:0] {
      C_NONE,
      C_HIT,
      C_UNPIN,
      C_DIRTY,
      C_CLEAN,
      C_DROP,
      C_LOAD,
      C_CLEAR
   } cop_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_TAIL,
      S_READ,
      S_SHOW
   } state_type;

   typedef struct packed {
      cop_type             op;
      logic [SLOT_IW-1:0]  idx;
      logic [SLOT_IW-1:0]  rec;
      logic [PAGE_W-1:0]   page;
   } cmd_type;

   // Scan token passed cell to cell
   typedef struct packed {
      logic                hit;
      logic [SLOT_IW-1:0]  hit_idx;
      logic [SLOT_IW-1:0]  hit_rec;
      logic [PIN_W-1:0]    hit_pins;
      logic                hit_dirty;
      logic                vic;
      logic [SLOT_IW-1:0]  vic_idx;
      logic [SLOT_IW-1:0]  vic_rec;
      logic                vic_dirty;
      logic [PAGE_W-1:0]   vic_page;
      logic                fre;
      logic [SLOT_IW-1:0]  fre_idx;
      logic                drt;
      logic [SLOT_IW-1:0]  drt_idx;
      logic [PAGE_W-1:0]   drt_page;
   } probe_type;

   typedef struct packed {
      status_type          status;
      action_type          action;
      logic [SLOT_IW-1:0]  slot;
      logic [PAGE_W-1:0]   target;
      logic [FL_W-1:0]     flushed;
      logic                last;
   } res_type;

   function automatic res_type make_res(status_type st, action_type act,
                                        logic [SLOT_IW-1:0] sl, logic [PAGE_W-1:0] tgt,
                                        logic [FL_W-1:0] fl, logic lst);
      res_type r;
      r.status  = st;
      r.action  = act;
      r.slot    = sl;
      r.target  = tgt;
      r.flushed = fl;
      r.last    = lst;
      return r;
   endfunction

endpackage

@@ rtl/plpd_cell.sv @@
// One directory slot: holds a page entry, applies commands, updates the scan token.
module plpd_cell import plpd_pkg::*; #(
   parameter int IDX = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [PAGE_W-1:0] key,
   input  cmd_type           cmd,
   input  probe_type         probe_in,
   output probe_type         probe_out
);

   logic                valid_ff, valid_in;
   logic [PAGE_W-1:0]   page_ff, page_in;
   logic [PIN_W-1:0]    pins_ff, pins_in;
   logic                dirty_ff, dirty_in;
   logic [SLOT_IW-1:0]  rec_ff, rec_in;
   probe_type           probe_ff, probe_in_c;
   logic                me;

   assign me = (cmd.idx == SLOT_IW'(IDX));

   // Apply the broadcast command
   always_comb begin
      valid_in = valid_ff;
      page_in  = page_ff;
      pins_in  = pins_ff;
      dirty_in = dirty_ff;
      rec_in   = rec_ff;
      case (cmd.op)
         C_HIT: begin
            if (me) begin
               rec_in = '0;
               if (pins_ff != '1) pins_in = pins_ff + 1'b1;
            end else if (valid_ff && rec_ff < cmd.rec) begin
               rec_in = rec_ff + 1'b1;
            end
         end
         C_UNPIN: begin
            if (me && pins_ff != '0) pins_in = pins_ff - 1'b1;
         end
         C_DIRTY: begin
            if (me) dirty_in = 1'b1;
         end
         C_CLEAN: begin
            if (me) dirty_in = 1'b0;
         end
         C_DROP: begin
            if (me) valid_in = 1'b0;
            else if (valid_ff && rec_ff > cmd.rec) rec_in = rec_ff - 1'b1;
         end
         C_LOAD: begin
            if (me) begin
               valid_in = 1'b1;
               page_in  = cmd.page;
               pins_in  = PIN_W'(1);
               dirty_in = 1'b0;
               rec_in   = '0;
            end else if (valid_ff) begin
               rec_in = rec_ff + 1'b1;
            end
         end
         C_CLEAR: valid_in = 1'b0;
         default: ;
      endcase
   end

   // Fold this slot into the scan token
   always_comb begin
      probe_in_c = probe_in;
      if (valid_ff && page_ff == key && !probe_in.hit) begin
         probe_in_c.hit       = 1'b1;
         probe_in_c.hit_idx   = SLOT_IW'(IDX);
         probe_in_c.hit_rec   = rec_ff;
         probe_in_c.hit_pins  = pins_ff;
         probe_in_c.hit_dirty = dirty_ff;
      end
      if (valid_ff && pins_ff == '0 && (!probe_in.vic || rec_ff > probe_in.vic_rec)) begin
         probe_in_c.vic       = 1'b1;
         probe_in_c.vic_idx   = SLOT_IW'(IDX);
         probe_in_c.vic_rec   = rec_ff;
         probe_in_c.vic_dirty = dirty_ff;
         probe_in_c.vic_page  = page_ff;
      end
      if (!valid_ff && !probe_in.fre) begin
         probe_in_c.fre     = 1'b1;
         probe_in_c.fre_idx = SLOT_IW'(IDX);
      end
      if (valid_ff && dirty_ff && !probe_in.drt) begin
         probe_in_c.drt      = 1'b1;
         probe_in_c.drt_idx  = SLOT_IW'(IDX);
         probe_in_c.drt_page = page_ff;
      end
   end

   // Clear valid under reset
   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   // Entry payload and token stage
   always_ff @(posedge clock) begin
      page_ff  <= page_in;
      pins_ff  <= pins_in;
      dirty_ff <= dirty_in;
      rec_ff   <= rec_in;
      probe_ff <= probe_in_c;
   end

   assign probe_out = probe_ff;

endmodule

@@ rtl/plpd_rfifo.sv @@
// Result buffer: one write port, one registered read port.
module plpd_rfifo import plpd_pkg::*; #(
   parameter int DEPTH = CAP_DEFAULT + 1
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  res_type                  wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output res_type                  rd_data
);

   res_type mem [DEPTH];
   res_type rd_data_ff;

   // Store and fetch entries
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/pinned_lru_page_directory_top.sv @@
// A scan token walks the CAPACITY slot cells for each directory lookup; each eviction by a GET
// and each write-back step of a FLUSH_ALL or CLEAR rescans. Results are buffered and then
// delivered one at a time, each held while rsp_stall is high, and the next request is taken
// the cycle after the last result transfer.
// Synchronous reset empties the directory, zeroes all counters and restores page_limit 16
// and backing store present; no clearing pass.
module pinned_lru_page_directory_top import plpd_pkg::*; #(
   parameter int CAPACITY = CAP_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_func,
   input  logic [31:0]        req_page_id,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_status,
   output logic [1:0]         rsp_action,
   output logic [3:0]         rsp_slot,
   output logic [31:0]        rsp_target_page,
   output logic [4:0]         rsp_flushed_count,
   output logic               rsp_last,
   output logic [31:0]        rsp_hit_total,
   output logic [31:0]        rsp_miss_total,
   output logic [4:0]         rsp_resident_count,
   output logic [31:0]        rsp_pin_total,
   output logic [31:0]        rsp_eviction_total,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   localparam int DEPTH  = CAPACITY + 1;
   localparam int AW     = $clog2(DEPTH);
   localparam int PTR_W  = $clog2(DEPTH + 1);
   localparam int WAIT_W = $clog2(CAPACITY + 1);

   state_type           state_ff, state_in;
   func_type            func_ff, func_in;
   logic [PAGE_W-1:0]   key_ff, key_in;
   logic [WAIT_W-1:0]   wait_ff, wait_in;
   logic                first_ff, first_in;
   logic [SLOT_IW-1:0]  tail_slot_ff, tail_slot_in;
   logic [FL_W-1:0]     cnt_ff, cnt_in;
   logic [FL_W-1:0]     resident_ff, resident_in;
   logic [CNT_W-1:0]    hits_ff, hits_in, misses_ff, misses_in;
   logic [CNT_W-1:0]    pins_ff, pins_in, evict_ff, evict_in;
   logic [LIMIT_W-1:0]  limit_ff, limit_in;
   logic                bsp_ff, bsp_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;

   cmd_type             cmd_c;
   logic                push_c, rd_en_c;
   res_type             push_data_c, rd_data;
   probe_type           chain [CAPACITY];
   probe_type           p;
   logic [FL_W-1:0]     lim_c;
   logic                req_take, cfg_write;

   assign req_take  = req_valid && !req_stall;
   assign cfg_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign p         = chain[CAPACITY-1];

   // Clamp the page limit to the legal range
   always_comb begin
      if (limit_ff == '0)                            lim_c = FL_W'(1);
      else if (FL_W'(limit_ff) > FL_W'(CAPACITY))    lim_c = FL_W'(CAPACITY);
      else                                           lim_c = FL_W'(limit_ff);
   end

   // Slot cells in a row; the scan token enters cell 0 empty
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_head
         plpd_cell #(.IDX(i)) u_cell (
            .clock     (clock),
            .reset     (reset),
            .key       (key_ff),
            .cmd       (cmd_c),
            .probe_in  (probe_type'('0)),
            .probe_out (chain[i])
         );
      end else begin : g_body
         plpd_cell #(.IDX(i)) u_cell (
            .clock     (clock),
            .reset     (reset),
            .key       (key_ff),
            .cmd       (cmd_c),
            .probe_in  (chain[i-1]),
            .probe_out (chain[i])
         );
      end
   end

   plpd_rfifo #(.DEPTH(DEPTH)) u_rfifo (
      .clock   (clock),
      .wr_en   (push_c),
      .wr_addr (wr_ptr_ff[AW-1:0]),
      .wr_data (push_data_c),
      .rd_en   (rd_en_c),
      .rd_addr (rd_ptr_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   // Sequencer: next state, cell commands, result pushes
   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      key_in       = key_ff;
      wait_in      = wait_ff;
      first_in     = first_ff;
      tail_slot_in = tail_slot_ff;
      cnt_in       = cnt_ff;
      resident_in  = resident_ff;
      hits_in      = hits_ff;
      misses_in    = misses_ff;
      pins_in      = pins_ff;
      evict_in     = evict_ff;
      rd_ptr_in    = rd_ptr_ff;
      wr_ptr_in    = wr_ptr_ff;
      cmd_c.op     = C_NONE;
      cmd_c.idx    = '0;
      cmd_c.rec    = '0;
      cmd_c.page   = key_ff;
      push_c       = 1'b0;
      push_data_c  = make_res(ST_OK, ACT_NONE, '0, '0, '0, 1'b0);
      rd_en_c      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               func_in   = func_type'(req_func);
               key_in    = req_page_id;
               wait_in   = WAIT_W'(CAPACITY);
               first_in  = 1'b1;
               cnt_in    = '0;
               rd_ptr_in = '0;
               wr_ptr_in = '0;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            if (wait_ff != '0) begin
               wait_in = wait_ff - 1'b1;
            end else begin
               case (func_ff)
                  F_GET: begin
                     if (first_ff) begin
                        if (p.hit) begin
                           hits_in     = hits_ff + 1'b1;
                           pins_in     = pins_ff + 1'b1;
                           cmd_c.op    = C_HIT;
                           cmd_c.idx   = p.hit_idx;
                           cmd_c.rec   = p.hit_rec;
                           push_c      = 1'b1;
                           push_data_c = make_res(ST_OK, ACT_NONE, p.hit_idx, key_ff, '0, 1'b1);
                           state_in    = S_READ;
                        end else begin
                           misses_in = misses_ff + 1'b1;
                           first_in  = 1'b0;
                           if (!bsp_ff) begin
                              push_c      = 1'b1;
                              push_data_c = make_res(ST_NO_STORE, ACT_NONE, '0, key_ff, '0, 1'b1);
                              state_in    = S_READ;
                           end
                        end
                     end else if (resident_ff >= lim_c) begin
                        if (!p.vic) begin
                           push_c      = 1'b1;
                           push_data_c = make_res(ST_NO_VICTIM, ACT_NONE, '0, key_ff, '0, 1'b1);
                           state_in    = S_READ;
                        end else begin
                           if (p.vic_dirty) begin
                              push_c      = 1'b1;
                              push_data_c = make_res(ST_OK, ACT_WB, p.vic_idx, p.vic_page,
                                                     '0, 1'b0);
                              wr_ptr_in   = wr_ptr_ff + 1'b1;
                           end
                           cmd_c.op    = C_DROP;
                           cmd_c.idx   = p.vic_idx;
                           cmd_c.rec   = p.vic_rec;
                           resident_in = resident_ff - 1'b1;
                           evict_in    = evict_ff + 1'b1;
                           wait_in     = WAIT_W'(CAPACITY);
                        end
                     end else begin
                        cmd_c.op    = C_LOAD;
                        cmd_c.idx   = p.fre_idx;
                        resident_in = resident_ff + 1'b1;
                        pins_in     = pins_ff + 1'b1;
                        push_c      = 1'b1;
                        push_data_c = make_res(ST_LOADED, ACT_READ, p.fre_idx, key_ff, '0, 1'b1);
                        state_in    = S_READ;
                     end
                  end
                  F_UNPIN, F_DIRTY, F_FLUSH, F_EVICT: begin
                     push_c      = 1'b1;
                     push_data_c = make_res(ST_OK, ACT_NONE, p.hit_idx, key_ff, '0, 1'b1);
                     state_in    = S_READ;
                     cmd_c.idx   = p.hit_idx;
                     cmd_c.rec   = p.hit_rec;
                     if (!p.hit) begin
                        push_data_c = make_res(ST_NOT_FOUND, ACT_NONE, '0, key_ff, '0, 1'b1);
                     end else if (func_ff == F_UNPIN) begin
                        cmd_c.op = C_UNPIN;
                     end else if (func_ff == F_DIRTY) begin
                        cmd_c.op = C_DIRTY;
                     end else if (func_ff == F_FLUSH) begin
                        if (p.hit_dirty && bsp_ff) begin
                           cmd_c.op    = C_CLEAN;
                           push_data_c = make_res(ST_OK, ACT_WB, p.hit_idx, key_ff, '0, 1'b1);
                        end
                     end else if (p.hit_pins != '0) begin
                        push_data_c = make_res(ST_PINNED, ACT_NONE, p.hit_idx, key_ff, '0, 1'b1);
                     end else begin
                        cmd_c.op    = C_DROP;
                        resident_in = resident_ff - 1'b1;
                        evict_in    = evict_ff + 1'b1;
                        if (p.hit_dirty && bsp_ff) begin
                           push_data_c  = make_res(ST_OK, ACT_WB, p.hit_idx, key_ff, '0, 1'b0);
                           wr_ptr_in    = wr_ptr_ff + 1'b1;
                           tail_slot_in = p.hit_idx;
                           state_in     = S_TAIL;
                        end
                     end
                  end
                  F_FLUSH_ALL, F_CLEAR: begin
                     push_c = 1'b1;
                     if (bsp_ff && p.drt) begin
                        push_data_c = make_res(ST_OK, ACT_WB, p.drt_idx, p.drt_page, '0, 1'b0);
                        wr_ptr_in   = wr_ptr_ff + 1'b1;
                        cmd_c.op    = C_CLEAN;
                        cmd_c.idx   = p.drt_idx;
                        cnt_in      = cnt_ff + 1'b1;
                        wait_in     = WAIT_W'(CAPACITY);
                     end else if (func_ff == F_FLUSH_ALL) begin
                        push_data_c = make_res(ST_OK, ACT_NONE, '0, '0, cnt_ff, 1'b1);
                        state_in    = S_READ;
                     end else begin
                        cmd_c.op    = C_CLEAR;
                        resident_in = '0;
                        push_data_c = make_res(ST_OK, ACT_NONE, '0, '0, '0, 1'b1);
                        state_in    = S_READ;
                     end
                  end
                  default: begin
                     hits_in     = '0;
                     misses_in   = '0;
                     pins_in     = '0;
                     evict_in    = '0;
                     push_c      = 1'b1;
                     push_data_c = make_res(ST_OK, ACT_NONE, '0, '0, '0, 1'b1);
                     state_in    = S_READ;
                  end
               endcase
            end
         end
         S_TAIL: begin
            push_c      = 1'b1;
            push_data_c = make_res(ST_OK, ACT_NONE, tail_slot_ff, key_ff, '0, 1'b1);
            state_in    = S_READ;
         end
         S_READ: begin
            rd_en_c  = 1'b1;
            state_in = S_SHOW;
         end
         S_SHOW: begin
            if (!rsp_stall) begin
               rd_ptr_in = rd_ptr_ff + 1'b1;
               if (rd_ptr_ff + 1'b1 == wr_ptr_ff) state_in = S_IDLE;
               else                               state_in = S_READ;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // Final pushes advance the write pointer
      if (push_c && state_in == S_READ) wr_ptr_in = wr_ptr_ff + 1'b1;
   end

   // Configuration writes
   always_comb begin
      limit_in = limit_ff;
      bsp_in   = bsp_ff;
      if (cfg_write) begin
         if (csr_paddr[2] == REG_LIMIT) limit_in = csr_pwdata[LIMIT_W-1:0];
         else                           bsp_in   = csr_pwdata[0];
      end
   end

   // Control state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         resident_ff <= '0;
         hits_ff     <= '0;
         misses_ff   <= '0;
         pins_ff     <= '0;
         evict_ff    <= '0;
         limit_ff    <= LIMIT_W'(16);
         bsp_ff      <= 1'b1;
         wait_ff     <= '0;
         rd_ptr_ff   <= '0;
         wr_ptr_ff   <= '0;
         first_ff    <= 1'b0;
         cnt_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         resident_ff <= resident_in;
         hits_ff     <= hits_in;
         misses_ff   <= misses_in;
         pins_ff     <= pins_in;
         evict_ff    <= evict_in;
         limit_ff    <= limit_in;
         bsp_ff      <= bsp_in;
         wait_ff     <= wait_in;
         rd_ptr_ff   <= rd_ptr_in;
         wr_ptr_ff   <= wr_ptr_in;
         first_ff    <= first_in;
         cnt_ff      <= cnt_in;
      end
   end

   // Request payload
   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      key_ff       <= key_in;
      tail_slot_ff <= tail_slot_in;
   end

   // Drive ports
   assign req_stall          = reset || (state_ff != S_IDLE);
   assign rsp_valid          = (state_ff == S_SHOW);
   assign rsp_status         = rd_data.status;
   assign rsp_action         = rd_data.action;
   assign rsp_slot           = rd_data.slot[3:0];
   assign rsp_target_page    = rd_data.target;
   assign rsp_flushed_count  = rd_data.flushed[4:0];
   assign rsp_last           = rd_data.last;
   assign rsp_hit_total      = hits_ff;
   assign rsp_miss_total     = misses_ff;
   assign rsp_resident_count = resident_ff[4:0];
   assign rsp_pin_total      = pins_ff;
   assign rsp_eviction_total = evict_ff;
   assign csr_pready         = 1'b1;
   assign csr_prdata         = (csr_paddr[2] == REG_STORE) ? {31'd0, bsp_ff}
                                                           : {27'd0, limit_ff};

endmodule

@@ rtl/plpd_checker.sv @@
// Port-level checks for the page directory, bound to the top level.
module plpd_checker import plpd_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_status,
   input logic [1:0]  rsp_action,
   input logic [31:0] rsp_target_page,
   input logic [4:0]  rsp_flushed_count,
   input logic        rsp_last
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_target_page) && $stable(rsp_last))
      else $error("stalled result changed");

   // Block new requests right after a transfer in
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall && !rsp_valid)
      else $error("request taken while busy");

   // Keep requests out while results are pending
   a_one_op: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request open while results pending");

   // Flush count appears only on a final reply
   a_flush_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_flushed_count != 5'd0 |-> rsp_last && rsp_action == ACT_NONE)
      else $error("flush count on non-final result");

   // Codes stay in range
   a_codes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= ST_NO_STORE) && (rsp_action != 2'd3))
      else $error("bad result code");

endmodule

bind pinned_lru_page_directory_top plpd_checker u_plpd_checker (.*);
